@@ design/pol_pkg.sv @@
// Shared types and constants for the positional ordered list.
`default_nettype none
package pol_pkg;

  localparam int DEPTH       = 16;
  localparam int HANDLE_W    = 32;
  localparam int FIELD_W     = 32;
  localparam int POS_W       = 8;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int IDX_W       = $clog2(DEPTH);
  localparam int CMP_W       = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int CMD_W       = 2;
  localparam int IN_TDATA_W  = ((POS_W + FIELD_W + 7) / 8) * 8;
  localparam int OUT_BITS    = FIELD_W + CNT_W + FIELD_W + FIELD_W;
  localparam int OUT_TDATA_W = ((OUT_BITS + 7) / 8) * 8;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [CMD_W-1:0] {
    OP_INSERT = 2'd0,
    OP_REMOVE = 2'd1,
    OP_READ   = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [POS_W-1:0]    pos;
    logic [HANDLE_W-1:0] handle;
  } cmd_t;

  typedef struct packed {
    logic                success;
    logic [HANDLE_W-1:0] elem;
    logic [CNT_W-1:0]    count;
    logic [HANDLE_W-1:0] first;
    logic [HANDLE_W-1:0] last;
  } rsp_t;

endpackage
`default_nettype wire

@@ design/pol_front.sv @@
// Front end: takes input transfers and decodes them into queue entries.
`default_nettype none
module pol_front
  import pol_pkg::*;
(
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  input  wire logic [CMD_W-1:0]      in_tuser,
  input  wire logic                  q_full,
  output logic                       q_push,
  output cmd_t                       q_wdata
);

  always_comb begin
    in_tready      = !q_full;
    q_push         = in_tvalid && !q_full;
    q_wdata.op     = op_t'(in_tuser);
    q_wdata.pos    = in_tdata[POS_W-1:0];
    // Only an insert carries a handle; zero it for the other commands.
    if (op_t'(in_tuser) == OP_INSERT) begin
      q_wdata.handle = HANDLE_W'(in_tdata[POS_W +: FIELD_W]);
    end else begin
      q_wdata.handle = '0;
    end
  end

endmodule
`default_nettype wire

@@ design/pol_queue.sv @@
// Short command queue between the front end and the cell chain.
`default_nettype none
module pol_queue
  import pol_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t wdata,
  output logic      full,
  output logic      not_empty,
  input  wire logic pop,
  output cmd_t      rdata
);

  cmd_t              mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  always_comb begin
    full       = (cnt_r == QCNT_W'(QUEUE_DEPTH));
    not_empty  = (cnt_r != '0);
    rdata      = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

@@ design/pol_back.sv @@
// Back end: chain of handle cells that shift by one place, plus the result register.
`default_nettype none
module pol_back
  import pol_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_not_empty,
  input  wire cmd_t q_rdata,
  output logic      q_pop,
  output logic      rsp_valid,
  input  wire logic rsp_ready,
  output rsp_t      rsp
);

  logic [HANDLE_W-1:0] cells_r   [DEPTH];
  logic [HANDLE_W-1:0] cells_nxt [DEPTH];
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                out_valid_r, out_valid_nxt;
  rsp_t                rsp_r, rsp_nxt;

  logic                ins_ok, rem_ok, rd_ok;
  logic [CMP_W-1:0]    pos_ext, cnt_ext, last_ext;
  logic [CNT_W-1:0]    last_idx, new_last;
  logic [IDX_W-1:0]    ipos, rpos;
  logic [HANDLE_W-1:0] handle;

  always_comb begin
    q_pop    = q_not_empty && (!out_valid_r || rsp_ready);
    pos_ext  = CMP_W'(q_rdata.pos);
    cnt_ext  = CMP_W'(count_r);
    last_idx = count_r - 1'b1;
    last_ext = CMP_W'(last_idx);
    ins_ok   = (q_rdata.op == OP_INSERT) && (count_r != CNT_W'(DEPTH));
    rem_ok   = (q_rdata.op == OP_REMOVE) && (count_r != '0);
    rd_ok    = (q_rdata.op == OP_READ) && (pos_ext < cnt_ext);
    // Clamp the position to the append slot or to the last handle.
    ipos     = (pos_ext > cnt_ext)  ? count_r[IDX_W-1:0]  : q_rdata.pos[IDX_W-1:0];
    rpos     = (pos_ext > last_ext) ? last_idx[IDX_W-1:0] : q_rdata.pos[IDX_W-1:0];
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    localparam logic [IDX_W-1:0] CellIdx = IDX_W'(i);
    always_comb begin
      cells_nxt[i] = cells_r[i];
      if (ins_ok) begin
        if (CellIdx == ipos) begin
          cells_nxt[i] = q_rdata.handle;
        end
        if (i > 0) begin
          if (CellIdx > ipos) begin
            cells_nxt[i] = cells_r[(i > 0) ? i - 1 : 0];
          end
        end
      end else if (rem_ok) begin
        if (i < DEPTH - 1) begin
          if (CellIdx >= rpos) begin
            cells_nxt[i] = cells_r[(i < DEPTH - 1) ? i + 1 : i];
          end
        end
      end
    end
  end

  always_comb begin
    handle    = '0;
    count_nxt = count_r;
    if (ins_ok) begin
      handle    = q_rdata.handle;
      count_nxt = count_r + 1'b1;
    end else if (rem_ok) begin
      handle    = cells_r[rpos];
      count_nxt = count_r - 1'b1;
    end else if (rd_ok) begin
      handle    = cells_r[q_rdata.pos[IDX_W-1:0]];
    end
    new_last        = count_nxt - 1'b1;
    rsp_nxt.success = ins_ok || rem_ok || rd_ok;
    rsp_nxt.elem    = handle;
    rsp_nxt.count   = count_nxt;
    if (count_nxt != '0) begin
      rsp_nxt.first = cells_nxt[0];
      rsp_nxt.last  = cells_nxt[new_last[IDX_W-1:0]];
    end else begin
      rsp_nxt.first = '0;
      rsp_nxt.last  = '0;
    end
    // Hold the result until taken; refill when a command is popped.
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (rsp_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      rsp_r <= rsp_nxt;
      for (int k = 0; k < DEPTH; k++) begin
        cells_r[k] <= cells_nxt[k];
      end
    end
  end

  assign rsp_valid = out_valid_r;
  assign rsp       = rsp_r;

endmodule
`default_nettype wire

@@ design/positional_ordered_list.sv @@
// Top level of the positional ordered list: front end, command queue and cell chain.
`default_nettype none
// Ordered list of up to DEPTH handles with insert, remove and read by position.
// Commands enter through a two-entry queue and are carried out by a chain of
// cells that shifts every stored handle by at most one place per command, so
// one command completes per cycle when the result side keeps up.
// A result passes from its input transfer through the queue write, then the
// cell update into the output register, and holds there until taken.
// Insert at or past the count appends; remove at or past the last index takes
// the last handle; a failed command reports success 0 and a zero handle with
// the unchanged count, first and last handles. No clearing pass after reset.
module positional_ordered_list
  import pol_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,   // position, element_value
  input  wire logic [CMD_W-1:0]       in_tuser,   // command
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,  // element_out, count_after,
                                                  // first_value, last_value
  output logic                        out_tuser   // success
);

  cmd_t q_wdata, q_rdata;
  logic q_push, q_pop, q_full, q_not_empty;
  rsp_t rsp;

  pol_front u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_wdata   (q_wdata)
  );

  pol_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .wdata     (q_wdata),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop       (q_pop),
    .rdata     (q_rdata)
  );

  pol_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rdata     (q_rdata),
    .q_pop       (q_pop),
    .rsp_valid   (out_tvalid),
    .rsp_ready   (out_tready),
    .rsp         (rsp)
  );

  assign out_tuser = rsp.success;
  assign out_tdata = OUT_TDATA_W'({FIELD_W'(rsp.last), FIELD_W'(rsp.first), rsp.count,
                                   FIELD_W'(rsp.elem)});

endmodule
`default_nettype wire

@@ design/pol_checker.sv @@
// Port-level checks for the positional ordered list and their bind.
`default_nettype none
module pol_checker
  import pol_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic                   out_tuser
);

  logic [FIELD_W-1:0] elem_w, first_w, last_w;
  logic [CNT_W-1:0]   count_w;

  assign elem_w  = out_tdata[0 +: FIELD_W];
  assign count_w = out_tdata[FIELD_W +: CNT_W];
  assign first_w = out_tdata[FIELD_W + CNT_W +: FIELD_W];
  assign last_w  = out_tdata[2 * FIELD_W + CNT_W +: FIELD_W];

  a_reset_idle: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && !out_tuser |-> elem_w == '0)
    else $error("failed command reports a nonzero handle");

  a_empty_ends: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid && count_w == '0 |-> first_w == '0 && last_w == '0)
    else $error("empty list reports nonzero first or last handle");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
      out_tvalid |-> count_w <= CNT_W'(DEPTH))
    else $error("count beyond capacity");

endmodule

bind positional_ordered_list pol_checker u_pol_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
`default_nettype wire
